>>> hw/rtl/tplve_pkg.sv
// Shared types, constants and vertex helper functions for the thick point
// and line vertex expander. No dependencies.
package tplve_pkg;

   localparam int COORD_W     = 24;
   localparam int STROKE_W    = 16;
   localparam int LEN_W       = 13;
   localparam int ADDR_W      = 2;
   localparam int CSR_W       = 16;
   localparam int TDATA_W     = 48;
   localparam int VSUM_W      = 28;   // vertex at 9 fraction bits
   localparam int OFS_W       = 20;   // signed offset at 9 fraction bits
   localparam int MAX_POINTS_DEF = 4096;

   localparam logic [STROKE_W-1:0] THICK_MIN = 16'd384;
   localparam logic [STROKE_W-1:0] STROKE_RST = 16'd256;

   // register indexes
   localparam logic [ADDR_W-1:0] REG_SHAPE_MODE   = 2'd0;
   localparam logic [ADDR_W-1:0] REG_STROKE_WIDTH = 2'd1;
   localparam logic [ADDR_W-1:0] REG_LIST_LENGTH  = 2'd2;

   // job kinds
   localparam logic [1:0] KIND_THIN    = 2'd0;
   localparam logic [1:0] KIND_SQUARE  = 2'd1;
   localparam logic [1:0] KIND_SEGMENT = 2'd2;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } job_type;

   // Round 9 fraction bits to 8 (ties up) and saturate to 24 bits.
   function automatic logic [COORD_W-1:0] to_q8(input logic signed [VSUM_W-1:0] v);
      logic signed [VSUM_W-1:0] r;
      begin
         r = (v + VSUM_W'(1)) >>> 1;
         if (r > VSUM_W'(8388607))
            to_q8 = 24'h7FFFFF;
         else if (r < -VSUM_W'(8388608))
            to_q8 = 24'h800000;
         else
            to_q8 = r[COORD_W-1:0];
      end
   endfunction

   // Segment quad: vertex uses the first point as base.
   function automatic logic seg_base_a(input logic [2:0] k);
      case (k)
         3'd0, 3'd3, 3'd5: seg_base_a = 1'b1;
         default:          seg_base_a = 1'b0;
      endcase
   endfunction

   // Segment quad: perpendicular shift subtracted.
   function automatic logic seg_neg(input logic [2:0] k);
      case (k)
         3'd2, 3'd4, 3'd5: seg_neg = 1'b1;
         default:          seg_neg = 1'b0;
      endcase
   endfunction

   // Square corners: half-width subtracted in x.
   function automatic logic sq_neg_x(input logic [2:0] k);
      case (k)
         3'd0, 3'd3, 3'd5: sq_neg_x = 1'b1;
         default:          sq_neg_x = 1'b0;
      endcase
   endfunction

   // Square corners: half-width subtracted in y.
   function automatic logic sq_neg_y(input logic [2:0] k);
      case (k)
         3'd0, 3'd1, 3'd3: sq_neg_y = 1'b1;
         default:          sq_neg_y = 1'b0;
      endcase
   endfunction

endpackage

>>> hw/rtl/tplve_front.sv
// Front end: configuration registers, list position and pair capture.
// Classifies points and pushes jobs to the queue. Uses tplve_pkg.
module tplve_front import tplve_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [CSR_W-1:0]    csr_wdata,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [COORD_W-1:0]  in_x,
   input  logic [COORD_W-1:0]  in_y,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job,
   output logic [STROKE_W-1:0] stroke
);

   localparam int PosW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CmpW = (PosW + 1 > LEN_W) ? PosW + 1 : LEN_W;

   logic                mode_ff, mode_in;
   logic [STROKE_W-1:0] stroke_ff, stroke_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [COORD_W-1:0]  first_x_ff, first_x_in, first_y_ff, first_y_in;

   logic [CmpW-1:0] len_eff, pos_inc, max_c;
   logic            accept, drop, thick;
   logic [PosW-1:0] pos_adv;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign stroke   = stroke_ff;
   assign thick    = stroke_ff >= THICK_MIN;

   // effective list length and wrapping position
   always_comb begin
      max_c   = CmpW'(MAX_POINTS);
      len_eff = (CmpW'(len_ff) > max_c) ? max_c : CmpW'(len_ff);
      pos_inc = CmpW'(pos_ff) + CmpW'(1);
      pos_adv = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
      drop    = (len_eff == '0) || (mode_ff && len_eff[0]);
   end

   // classification
   always_comb begin
      mode_in    = mode_ff;
      stroke_in  = stroke_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      q_push     = 1'b0;
      q_job.kind = KIND_THIN;
      q_job.ax   = first_x_ff;
      q_job.ay   = first_y_ff;
      q_job.cx   = in_x;
      q_job.cy   = in_y;
      if (accept && !drop) begin
         pos_in = pos_adv;
         if (!thick) begin
            q_push = 1'b1;
         end else if (!mode_ff) begin
            q_push     = 1'b1;
            q_job.kind = KIND_SQUARE;
         end else if (!pos_ff[0]) begin
            first_x_in = in_x;
            first_y_in = in_y;
         end else begin
            q_push     = 1'b1;
            q_job.kind = KIND_SEGMENT;
         end
      end
      if (csr_we) begin
         case (csr_addr)
            REG_SHAPE_MODE: begin
               mode_in = csr_wdata[0];
               pos_in  = '0;
            end
            REG_STROKE_WIDTH: stroke_in = csr_wdata[STROKE_W-1:0];
            REG_LIST_LENGTH: begin
               len_in = csr_wdata[LEN_W-1:0];
               pos_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         stroke_ff  <= STROKE_RST;
         len_ff     <= '0;
         pos_ff     <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         stroke_ff  <= stroke_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      CmpW'(pos_ff) < max_c) else $error("position beyond list");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");
   a_cfg_clears_pos: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_addr == REG_LIST_LENGTH) |=> pos_ff == '0)
      else $error("length write kept position");

endmodule

>>> hw/rtl/tplve_queue.sv
// Two-entry job queue between front end and vertex engine.
// Uses tplve_pkg for the job type.
module tplve_queue import tplve_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ff == rd_ff)
      else $error("queue pointers out of step");

endmodule

>>> hw/rtl/tplve_back.sv
// Vertex engine: segment length by iterative square root, shift by shared
// restoring divider, then vertex emission into the output register. Uses tplve_pkg.
module tplve_back import tplve_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  job_type             q_job,
   output logic                q_pop,
   input  logic [STROKE_W-1:0] stroke,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,
   output logic                rsp_tlast
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQR  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   localparam int DW = 25;   // coordinate difference
   localparam int QW = 18;   // shift quotient
   localparam int RW = 50;   // divider remainder

   logic [2:0]                state_ff;
   job_type                   job_ff;
   logic signed [DW-1:0]      dx_ff, dy_ff;
   logic [DW-1:0]             adx_ff, ady_ff;
   logic [2*DW-1:0]           sqx_ff, sqy_ff;
   logic [63:0]               n_ff, bit_ff;
   logic [63:0]               res_ff;    // partial root runs as wide as the bit
   logic                      big_ff, sel_y_ff;
   logic [DW+STROKE_W-1:0]    prod_ff;
   logic [RW-1:0]             rem_ff, dv_ff;
   logic [QW-1:0]             q_ff;
   logic [4:0]                step_ff;
   logic signed [OFS_W-1:0]   sx_ff, sy_ff;
   logic [2:0]                vk_ff;
   logic                      ovalid_ff;
   logic [TDATA_W-1:0]        odata_ff;
   logic                      olast_ff;

   logic [64:0]               rb;
   logic [RW-1:0]             rem_new;
   logic [QW-1:0]             q_new;
   logic signed [OFS_W-1:0]   q_sgn, ox, oy;
   logic signed [VSUM_W-1:0]  bx, by, vx, vy;
   logic                      load, last_v, negx, negy, base_a;
   logic [2:0]                vnum_m1;

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign load       = (state_ff == ST_EMIT) && (!ovalid_ff || rsp_tready);

   // divider step and signed quotient
   always_comb begin
      rb      = {1'b0, res_ff} + {1'b0, bit_ff};
      rem_new = rem_ff;
      q_new   = q_ff;
      if (rem_ff >= dv_ff) begin
         rem_new = rem_ff - dv_ff;
         q_new   = q_ff | (QW'(1) << step_ff);
      end
      q_sgn = sel_y_ff ? (dx_ff < 0 ? -OFS_W'(q_new) : OFS_W'(q_new))
                       : (dy_ff > 0 ? -OFS_W'(q_new) : OFS_W'(q_new));
   end

   // vertex of the current job
   always_comb begin
      vnum_m1 = (job_ff.kind == KIND_THIN) ? 3'd0 : 3'd5;
      last_v  = vk_ff == vnum_m1;
      case (job_ff.kind)
         KIND_SQUARE: begin
            base_a = 1'b0;
            negx   = sq_neg_x(vk_ff);
            negy   = sq_neg_y(vk_ff);
            ox     = OFS_W'(stroke);
            oy     = OFS_W'(stroke);
         end
         KIND_SEGMENT: begin
            base_a = seg_base_a(vk_ff);
            negx   = seg_neg(vk_ff);
            negy   = seg_neg(vk_ff);
            ox     = sx_ff;
            oy     = sy_ff;
         end
         default: begin
            base_a = 1'b0;
            negx   = 1'b0;
            negy   = 1'b0;
            ox     = '0;
            oy     = '0;
         end
      endcase
      bx = base_a ? (VSUM_W'(job_ff.ax) <<< 1) : (VSUM_W'(job_ff.cx) <<< 1);
      by = base_a ? (VSUM_W'(job_ff.ay) <<< 1) : (VSUM_W'(job_ff.cy) <<< 1);
      vx = bx + VSUM_W'(256) + (negx ? -VSUM_W'(ox) : VSUM_W'(ox));
      vy = by + VSUM_W'(256) + (negy ? -VSUM_W'(oy) : VSUM_W'(oy));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (rsp_tready) ovalid_ff <= 1'b0;
         if (load)       ovalid_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: if (q_valid)
               state_ff <= (q_job.kind == KIND_SEGMENT) ? ST_SQR : ST_EMIT;
            ST_SQR:  state_ff <= ST_SUM;
            ST_SUM:  state_ff <= ST_ROOT;
            ST_ROOT: if (step_ff == 5'd0) state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_DIV;
            ST_DIV:  if (step_ff == 5'd0) state_ff <= sel_y_ff ? ST_EMIT : ST_MUL;
            ST_EMIT: if (load && last_v) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff   <= q_job;
            vk_ff    <= '0;
            sel_y_ff <= 1'b0;
            sx_ff    <= '0;
            sy_ff    <= '0;
            dx_ff    <= DW'(q_job.cx) - DW'(q_job.ax);
            dy_ff    <= DW'(q_job.cy) - DW'(q_job.ay);
         end
         ST_SQR: begin
            adx_ff <= dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
            ady_ff <= dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
         end
         ST_SUM: begin
            sqx_ff  <= adx_ff * adx_ff;
            sqy_ff  <= ady_ff * ady_ff;
            res_ff  <= '0;
            bit_ff  <= 64'd1 << 62;
            step_ff <= 5'd31;
         end
         ST_ROOT: begin
            if (step_ff == 5'd31) begin
               // first step latches the radicand
               n_ff   <= ({14'd0, sqx_ff} + {14'd0, sqy_ff}) << 14;
               big_ff <= ({1'b0, sqx_ff} + {1'b0, sqy_ff}) > 51'd16384;
               step_ff <= 5'd30;
            end else if (step_ff != 5'd0) begin
               // root complete once step reaches zero; hold it there
               if ({1'b0, n_ff} >= rb) begin
                  n_ff   <= n_ff - rb[63:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff != 64'd1) step_ff <= 5'd30;
               else                 step_ff <= 5'd0;
            end
         end
         ST_MUL: begin
            prod_ff <= (sel_y_ff ? adx_ff : ady_ff) * stroke;
            step_ff <= 5'(QW);
            q_ff    <= '0;
         end
         ST_DIV: begin
            if (step_ff == 5'(QW)) begin
               rem_ff  <= RW'({prod_ff, 7'd0}) + RW'(res_ff >> 1);
               dv_ff   <= RW'(res_ff) << (QW - 1);
               step_ff <= 5'(QW - 1);
            end else begin
               rem_ff <= rem_new;
               q_ff   <= q_new;
               dv_ff  <= dv_ff >> 1;
               if (step_ff != 5'd0) step_ff <= step_ff - 5'd1;
               else if (!sel_y_ff) begin
                  sx_ff    <= big_ff ? q_sgn : '0;
                  sel_y_ff <= 1'b1;
                  step_ff  <= 5'(QW);
               end else begin
                  sy_ff <= big_ff ? q_sgn : '0;
               end
            end
         end
         ST_EMIT: if (load) vk_ff <= vk_ff + 3'd1;
         default: ;
      endcase
      if (load) begin
         odata_ff <= {to_q8(vy), to_q8(vx)};
         olast_ff <= last_v;
      end
   end

   a_vk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> vk_ff <= vnum_m1) else $error("vertex index overrun");
   a_last_leaves: assert property (@(posedge clock) disable iff (reset)
      (load && last_v) |=> (olast_ff && state_ff == ST_IDLE))
      else $error("last vertex did not end job");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != ST_IDLE) else $error("job popped but not started");

endmodule

>>> hw/rtl/thick_point_line_vertex_expand_core.sv
// Top level of the thick point and line vertex expander.
// Instantiates tplve_front, tplve_queue and tplve_back; uses tplve_pkg.
//
// Usage: points arrive on the req_ stream (tdata = point_x, point_y), triangle
// list vertices leave on the rsp_ stream (tdata = vertex_x, vertex_y; tlast
// marks the final vertex caused by a point). csr_ writes set shape_mode (0),
// stroke_width (1) and list_length (2); write only while idle.
// Output: a thin point gives one vertex; a thick point gives six vertices, one
// a cycle while the receiver keeps up. A line segment runs a 32-step square
// root then two restoring divisions in one shared divider before its six
// vertices. The first point of a thick pair only updates state.
// A two-entry job queue lets the front end accept points while the engine
// works. When the receiver stalls, the output register holds its vertex and
// the queue fills, then req_tready drops.
// Reset: synchronous, active high; registers return to shape_mode 0,
// stroke_width 1.0, list_length 0, position 0. No clearing pass.
module thick_point_line_vertex_expand_core import tplve_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // point_x [23:0], point_y [47:24]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // vertex_x [23:0], vertex_y [47:24]
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [ADDR_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic                q_full, q_push, q_pop, q_ne;
   job_type             push_job, head_job;
   logic [STROKE_W-1:0] stroke;

   tplve_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_x     (req_tdata[COORD_W-1:0]),
      .in_y     (req_tdata[2*COORD_W-1:COORD_W]),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job),
      .stroke   (stroke)
   );

   tplve_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_ne),
      .head     (head_job)
   );

   tplve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_ne),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .stroke    (stroke),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
